>>> sv/traffic_flow_statistics_counter_core_defines.svh
// Assertion macros for the traffic flow statistics counter checker.
// Included by the checker; depends on nothing else.
`ifndef TRAFFIC_FLOW_STATISTICS_COUNTER_CORE_DEFINES_SVH
`define TRAFFIC_FLOW_STATISTICS_COUNTER_CORE_DEFINES_SVH

// implication checked on every rising edge outside reset
`define TFSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfsc assertion failed");

// next-cycle implication
`define TFSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfsc assertion failed");

`endif

>>> sv/tfsc_pkg.sv
// Shared constants, codes and the command type of the statistics counter.
// No dependencies.
package tfsc_pkg;

	localparam int HIST_MAX_LEN = 4096;
	localparam int PORT_SLOTS   = 65536;
	localparam int ICMP_TYPES   = 256;
	localparam int HIST_BINS    = HIST_MAX_LEN + 2;

	localparam int PORT_AW = $clog2(PORT_SLOTS);
	localparam int HIST_AW = $clog2(HIST_BINS);
	localparam int ICMP_AW = $clog2(ICMP_TYPES);

	localparam int CLR_DEPTH0 = (PORT_SLOTS > HIST_BINS) ? PORT_SLOTS : HIST_BINS;
	localparam int CLR_DEPTH  = (CLR_DEPTH0 > ICMP_TYPES) ? CLR_DEPTH0 : ICMP_TYPES;
	localparam int CLR_W      = $clog2(CLR_DEPTH);

	localparam int QUEUE_DEPTH = 2;
	localparam int QAW         = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] WELL_KNOWN_END = 16'd1024;
	localparam logic [15:0] LAST_WELL_KNOWN = 16'd1023;

	localparam logic [2:0] OP_OTHER = 3'd0;
	localparam logic [2:0] OP_TCP   = 3'd1;
	localparam logic [2:0] OP_UDP   = 3'd2;
	localparam logic [2:0] OP_ICMP  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [3:0] TBL_TCP_SRC    = 4'd0;
	localparam logic [3:0] TBL_TCP_DST    = 4'd1;
	localparam logic [3:0] TBL_UDP_SRC    = 4'd2;
	localparam logic [3:0] TBL_UDP_DST    = 4'd3;
	localparam logic [3:0] TBL_ICMP       = 4'd4;
	localparam logic [3:0] TBL_HIST       = 4'd5;
	localparam logic [3:0] TBL_TCP_HIGH   = 4'd6;
	localparam logic [3:0] TBL_TCP_TOTAL  = 4'd7;
	localparam logic [3:0] TBL_UDP_HIGH   = 4'd8;
	localparam logic [3:0] TBL_UDP_TOTAL  = 4'd9;
	localparam logic [3:0] TBL_ICMP_TOTAL = 4'd10;
	localparam logic [3:0] TBL_PKT_COUNT  = 4'd11;
	localparam logic [3:0] TBL_BYTE_COUNT = 4'd12;

	typedef struct packed {
		logic               is_read;
		logic               is_tcp;
		logic               is_udp;
		logic               is_icmp;
		logic               upd_src;
		logic               upd_dst;
		logic               upd_high;
		logic               idx_bad;
		logic [3:0]         table_sel;
		logic [PORT_AW-1:0] src_idx;
		logic [PORT_AW-1:0] dst_idx;
		logic [ICMP_AW-1:0] icmp_idx;
		logic [HIST_AW-1:0] hist_idx;
		logic [15:0]        len;
	} cmd_t;

endpackage

>>> sv/tfsc_if.sv
// Item channels of the statistics counter: packet/read input and read result.
// No dependencies.
interface tfsc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  icmp_type;
	logic [15:0] pkt_length;
	logic [3:0]  read_table;
	logic [15:0] read_index;

	modport source (output valid, op, src_port, dst_port, icmp_type, pkt_length,
		read_table, read_index, input ready);
	modport sink (input valid, op, src_port, dst_port, icmp_type, pkt_length,
		read_table, read_index, output ready);
endinterface

interface tfsc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_value;
	logic        index_bad;

	modport source (output valid, read_value, index_bad, input ready);
	modport sink (input valid, read_value, index_bad, output ready);
endinterface

>>> sv/traffic_flow_statistics_counter_core.sv
// Top level of the traffic flow statistics counter.
// Depends on tfsc_pkg, tfsc_if, tfsc_front, tfsc_queue and tfsc_back.

// After reset the block clears all counter memories in a pass over the
// largest memory depth, during which no item is taken. Each accepted
// packet or read then takes two steps in the back end: a read of the
// counter memories, then a write of the updated counters or a load of the result.
// A two-entry command queue parts intake from execution, and a read result
// is held in an output register until taken; while it waits a further read
// stalls in the back end. Unused op codes are taken and dropped.
module traffic_flow_statistics_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	tfsc_in_if.sink     pkt_in,
	tfsc_out_if.source  res_out
);
	logic           push, q_ready, pop, head_valid, clearing;
	tfsc_pkg::cmd_t push_cmd, head_cmd;

	tfsc_front u_front (
		.pkt_in, .clearing, .q_ready, .push, .cmd(push_cmd));

	tfsc_queue u_queue (
		.clk, .arst_n, .push, .push_cmd, .push_ready(q_ready),
		.pop, .head_valid, .head_cmd);

	tfsc_back u_back (
		.clk, .arst_n, .head_valid, .head_cmd, .pop, .clearing, .res_out);
endmodule

>>> sv/tfsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> sv/tfsc_front.sv
// Front end: accepts items, classifies ports and indexes into a command.
// Depends on tfsc_pkg and tfsc_if.
module tfsc_front (
	tfsc_in_if.sink          pkt_in,
	input  logic             clearing,
	input  logic             q_ready,
	output logic             push,
	output tfsc_pkg::cmd_t   cmd
);
	logic [15:0] s, d, idx;
	logic        c_src_only, c_dst_only, c_both, c_high, src_ok, dst_ok;

	assign s   = pkt_in.src_port;
	assign d   = pkt_in.dst_port;
	assign idx = pkt_in.read_index;

	assign pkt_in.ready = q_ready && !clearing;
	// unused op codes are taken and dropped
	assign push = pkt_in.valid && pkt_in.ready && (pkt_in.op <= tfsc_pkg::OP_READ);

	always_comb begin
		c_src_only = (s < tfsc_pkg::WELL_KNOWN_END) && (d > tfsc_pkg::LAST_WELL_KNOWN);
		c_dst_only = (d < tfsc_pkg::WELL_KNOWN_END) && (s > tfsc_pkg::LAST_WELL_KNOWN);
		c_both     = (s < tfsc_pkg::LAST_WELL_KNOWN) && (d < tfsc_pkg::LAST_WELL_KNOWN);
		c_high     = (s > tfsc_pkg::LAST_WELL_KNOWN) && (d > tfsc_pkg::LAST_WELL_KNOWN);
		src_ok     = {1'b0, s} < 17'(tfsc_pkg::PORT_SLOTS);
		dst_ok     = {1'b0, d} < 17'(tfsc_pkg::PORT_SLOTS);

		cmd           = '0;
		cmd.is_read   = (pkt_in.op == tfsc_pkg::OP_READ);
		cmd.is_tcp    = (pkt_in.op == tfsc_pkg::OP_TCP);
		cmd.is_udp    = (pkt_in.op == tfsc_pkg::OP_UDP);
		cmd.is_icmp   = (pkt_in.op == tfsc_pkg::OP_ICMP);
		cmd.upd_src   = (c_src_only || c_both || c_high) && src_ok;
		cmd.upd_dst   = (c_dst_only || c_both || c_high) && dst_ok;
		cmd.upd_high  = c_high;
		cmd.table_sel = pkt_in.read_table;
		cmd.len       = pkt_in.pkt_length;

		if (cmd.is_read) begin
			cmd.src_idx  = idx[tfsc_pkg::PORT_AW-1:0];
			cmd.dst_idx  = idx[tfsc_pkg::PORT_AW-1:0];
			cmd.icmp_idx = idx[tfsc_pkg::ICMP_AW-1:0];
			cmd.hist_idx = idx[tfsc_pkg::HIST_AW-1:0];
		end else begin
			cmd.src_idx  = s[tfsc_pkg::PORT_AW-1:0];
			cmd.dst_idx  = d[tfsc_pkg::PORT_AW-1:0];
			cmd.icmp_idx = pkt_in.icmp_type[tfsc_pkg::ICMP_AW-1:0];
			if ({16'd0, pkt_in.pkt_length} <= 32'(tfsc_pkg::HIST_MAX_LEN)) begin
				cmd.hist_idx = pkt_in.pkt_length[tfsc_pkg::HIST_AW-1:0];
			end else begin
				cmd.hist_idx = tfsc_pkg::HIST_AW'(tfsc_pkg::HIST_MAX_LEN + 1);
			end
		end

		case (pkt_in.read_table)
			tfsc_pkg::TBL_TCP_SRC, tfsc_pkg::TBL_TCP_DST,
			tfsc_pkg::TBL_UDP_SRC, tfsc_pkg::TBL_UDP_DST: begin
				cmd.idx_bad = !({1'b0, idx} < 17'(tfsc_pkg::PORT_SLOTS));
			end
			tfsc_pkg::TBL_ICMP: begin
				cmd.idx_bad = !({1'b0, idx} < 17'(tfsc_pkg::ICMP_TYPES));
			end
			tfsc_pkg::TBL_HIST: begin
				cmd.idx_bad = !({1'b0, idx} < 17'(tfsc_pkg::HIST_BINS));
			end
			tfsc_pkg::TBL_TCP_HIGH, tfsc_pkg::TBL_TCP_TOTAL, tfsc_pkg::TBL_UDP_HIGH,
			tfsc_pkg::TBL_UDP_TOTAL, tfsc_pkg::TBL_ICMP_TOTAL, tfsc_pkg::TBL_PKT_COUNT,
			tfsc_pkg::TBL_BYTE_COUNT: begin
				cmd.idx_bad = 1'b0;
			end
			default: begin
				cmd.idx_bad = 1'b1;
			end
		endcase
	end
endmodule

>>> sv/tfsc_queue.sv
// Short command queue between front and back end.
// Depends on tfsc_pkg.
module tfsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tfsc_pkg::cmd_t push_cmd,
	output logic           push_ready,
	input  logic           pop,
	output logic           head_valid,
	output tfsc_pkg::cmd_t head_cmd
);
	tfsc_pkg::cmd_t            entry_q [tfsc_pkg::QUEUE_DEPTH];
	logic [tfsc_pkg::QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [tfsc_pkg::QAW:0]    count_q;

	assign push_ready = count_q != (tfsc_pkg::QAW+1)'(tfsc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> sv/tfsc_back.sv
// Back end: clearing pass, counter memories, read-modify-write and result register.
// Depends on tfsc_pkg, tfsc_if and tfsc_ram.
module tfsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  tfsc_pkg::cmd_t  head_cmd,
	output logic            pop,
	output logic            clearing,
	tfsc_out_if.source      res_out
);
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]                  state_q;
	logic [tfsc_pkg::CLR_W-1:0]  clr_cnt_q;
	tfsc_pkg::cmd_t              cur_q;
	logic                        out_valid_q, out_bad_q;
	logic [63:0]                 out_value_q;
	logic [63:0] tcp_high_q, tcp_total_q, udp_high_q, udp_total_q;
	logic [63:0] icmp_total_q, pkt_count_q, byte_count_q;

	logic        clr, exec_pkt, load_res;
	logic [63:0] len64, rd_val;
	logic [tfsc_pkg::PORT_AW-1:0] src_wa, dst_wa, src_ra, dst_ra;
	logic [tfsc_pkg::ICMP_AW-1:0] icmp_wa, icmp_ra;
	logic [tfsc_pkg::HIST_AW-1:0] hist_wa, hist_ra;
	logic        port_clr, icmp_clr, hist_clr;
	logic [63:0] ts_rd, td_rd, us_rd, ud_rd, ic_rd, hi_rd;
	logic [63:0] ts_wd, td_wd, us_wd, ud_wd, ic_wd, hi_wd;

	assign clr      = state_q == ST_CLEAR;
	assign clearing = clr;
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign exec_pkt = (state_q == ST_EXEC) && !cur_q.is_read;
	// a result waits in the back end until the output register is empty
	assign load_res = (state_q == ST_EXEC) && cur_q.is_read && !out_valid_q;
	assign len64    = {48'd0, cur_q.len};

	assign port_clr = clr && ({1'b0, clr_cnt_q} < (tfsc_pkg::CLR_W+1)'(tfsc_pkg::PORT_SLOTS));
	assign icmp_clr = clr && ({1'b0, clr_cnt_q} < (tfsc_pkg::CLR_W+1)'(tfsc_pkg::ICMP_TYPES));
	assign hist_clr = clr && ({1'b0, clr_cnt_q} < (tfsc_pkg::CLR_W+1)'(tfsc_pkg::HIST_BINS));

	assign src_wa  = clr ? clr_cnt_q[tfsc_pkg::PORT_AW-1:0] : cur_q.src_idx;
	assign dst_wa  = clr ? clr_cnt_q[tfsc_pkg::PORT_AW-1:0] : cur_q.dst_idx;
	assign icmp_wa = clr ? clr_cnt_q[tfsc_pkg::ICMP_AW-1:0] : cur_q.icmp_idx;
	assign hist_wa = clr ? clr_cnt_q[tfsc_pkg::HIST_AW-1:0] : cur_q.hist_idx;
	assign src_ra  = head_cmd.src_idx;
	assign dst_ra  = head_cmd.dst_idx;
	assign icmp_ra = head_cmd.icmp_idx;
	assign hist_ra = head_cmd.hist_idx;

	assign ts_wd = clr ? 64'd0 : ts_rd + len64;
	assign td_wd = clr ? 64'd0 : td_rd + len64;
	assign us_wd = clr ? 64'd0 : us_rd + len64;
	assign ud_wd = clr ? 64'd0 : ud_rd + len64;
	assign ic_wd = clr ? 64'd0 : ic_rd + len64;
	assign hi_wd = clr ? 64'd0 : hi_rd + 64'd1;

	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::PORT_SLOTS)) u_tcp_src (
		.clk, .we(port_clr || (exec_pkt && cur_q.is_tcp && cur_q.upd_src)),
		.waddr(src_wa), .wdata(ts_wd), .re(pop), .raddr(src_ra), .rdata(ts_rd));
	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::PORT_SLOTS)) u_tcp_dst (
		.clk, .we(port_clr || (exec_pkt && cur_q.is_tcp && cur_q.upd_dst)),
		.waddr(dst_wa), .wdata(td_wd), .re(pop), .raddr(dst_ra), .rdata(td_rd));
	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::PORT_SLOTS)) u_udp_src (
		.clk, .we(port_clr || (exec_pkt && cur_q.is_udp && cur_q.upd_src)),
		.waddr(src_wa), .wdata(us_wd), .re(pop), .raddr(src_ra), .rdata(us_rd));
	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::PORT_SLOTS)) u_udp_dst (
		.clk, .we(port_clr || (exec_pkt && cur_q.is_udp && cur_q.upd_dst)),
		.waddr(dst_wa), .wdata(ud_wd), .re(pop), .raddr(dst_ra), .rdata(ud_rd));
	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::ICMP_TYPES)) u_icmp (
		.clk, .we(icmp_clr || (exec_pkt && cur_q.is_icmp)),
		.waddr(icmp_wa), .wdata(ic_wd), .re(pop), .raddr(icmp_ra), .rdata(ic_rd));
	tfsc_ram #(.WIDTH(64), .DEPTH(tfsc_pkg::HIST_BINS)) u_hist (
		.clk, .we(hist_clr || exec_pkt),
		.waddr(hist_wa), .wdata(hi_wd), .re(pop), .raddr(hist_ra), .rdata(hi_rd));

	always_comb begin
		case (cur_q.table_sel)
			tfsc_pkg::TBL_TCP_SRC:    rd_val = ts_rd;
			tfsc_pkg::TBL_TCP_DST:    rd_val = td_rd;
			tfsc_pkg::TBL_UDP_SRC:    rd_val = us_rd;
			tfsc_pkg::TBL_UDP_DST:    rd_val = ud_rd;
			tfsc_pkg::TBL_ICMP:       rd_val = ic_rd;
			tfsc_pkg::TBL_HIST:       rd_val = hi_rd;
			tfsc_pkg::TBL_TCP_HIGH:   rd_val = tcp_high_q;
			tfsc_pkg::TBL_TCP_TOTAL:  rd_val = tcp_total_q;
			tfsc_pkg::TBL_UDP_HIGH:   rd_val = udp_high_q;
			tfsc_pkg::TBL_UDP_TOTAL:  rd_val = udp_total_q;
			tfsc_pkg::TBL_ICMP_TOTAL: rd_val = icmp_total_q;
			tfsc_pkg::TBL_PKT_COUNT:  rd_val = pkt_count_q;
			tfsc_pkg::TBL_BYTE_COUNT: rd_val = byte_count_q;
			default:                  rd_val = 64'd0;
		endcase
		if (cur_q.idx_bad) begin
			rd_val = 64'd0;
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.read_value = out_value_q;
	assign res_out.index_bad  = out_bad_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_cmd;
		end
		if (load_res) begin
			out_value_q <= rd_val;
			out_bad_q   <= cur_q.idx_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			tcp_high_q   <= '0;
			tcp_total_q  <= '0;
			udp_high_q   <= '0;
			udp_total_q  <= '0;
			icmp_total_q <= '0;
			pkt_count_q  <= '0;
			byte_count_q <= '0;
		end else begin
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (exec_pkt) begin
				if (cur_q.is_tcp) begin
					tcp_total_q <= tcp_total_q + len64;
					if (cur_q.upd_high) begin
						tcp_high_q <= tcp_high_q + len64;
					end
				end
				if (cur_q.is_udp) begin
					udp_total_q <= udp_total_q + len64;
					if (cur_q.upd_high) begin
						udp_high_q <= udp_high_q + len64;
					end
				end
				if (cur_q.is_icmp) begin
					icmp_total_q <= icmp_total_q + len64;
				end
				pkt_count_q  <= pkt_count_q + 64'd1;
				byte_count_q <= byte_count_q + len64;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == tfsc_pkg::CLR_W'(tfsc_pkg::CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!cur_q.is_read || load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> sv/tfsc_checker.sv
// Port-level checks of the statistics counter, bound to the top level.
// Depends on traffic_flow_statistics_counter_core_defines.svh.
`include "traffic_flow_statistics_counter_core_defines.svh"

module tfsc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_value,
	input logic        out_bad
);
	// a stalled result holds
	`TFSC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_bad))
	// a bad index always reads as zero
	`TFSC_ASSERT_IMP(a_bad_zero, clk, arst_n, out_valid && out_bad, out_value == 64'd0)
	// a taken result is never directly followed by another
	`TFSC_ASSERT_NXT(a_res_gap, clk, arst_n, out_valid && out_ready, !out_valid)
endmodule

bind traffic_flow_statistics_counter_core tfsc_port_checker u_tfsc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_value(res_out.read_value), .out_bad(res_out.index_bad));

>>> tb/tfsc_checker.sv
// Checker for the traffic flow statistics counter: predicts the counters from
// accepted packet items and checks each read result. Uses tfsc_pkg and tfsc_if.
module tfsc_checker (
	input  logic      clk,
	input  logic      arst_n,
	tfsc_in_if.sink   pkt_in,
	tfsc_out_if.sink  res_out,
	output int        errors,
	output int        pending,
	output int        reads_seen,
	output int        pkts_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import tfsc_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic        bad;
	} read_exp_t;

	bit [63:0] tcp_src [bit [15:0]];
	bit [63:0] tcp_dst [bit [15:0]];
	bit [63:0] udp_src [bit [15:0]];
	bit [63:0] udp_dst [bit [15:0]];
	bit [63:0] icmp_bytes [ICMP_TYPES];
	bit [63:0] len_hist [HIST_BINS];
	bit [63:0] tcp_high, tcp_total, udp_high, udp_total, icmp_total;
	bit [63:0] pkt_count, byte_count;
	read_exp_t read_q [$];

	function automatic bit [63:0] port_bytes(ref bit [63:0] tab [bit [15:0]],
			input bit [15:0] port);
		return tab.exists(port) ? tab[port] : 64'd0;
	endfunction

	task automatic count_ports(ref bit [63:0] src [bit [15:0]],
			ref bit [63:0] dst [bit [15:0]], ref bit [63:0] high,
			ref bit [63:0] total, input bit [15:0] s, input bit [15:0] d,
			input bit [63:0] len);
		// first matching rule wins; pairs of 1023 and a port below 1024 only hit the total
		if (s < WELL_KNOWN_END && d > LAST_WELL_KNOWN) begin
			src[s] = port_bytes(src, s) + len;
		end else if (d < WELL_KNOWN_END && s > LAST_WELL_KNOWN) begin
			dst[d] = port_bytes(dst, d) + len;
		end else if (s < LAST_WELL_KNOWN && d < LAST_WELL_KNOWN) begin
			src[s] = port_bytes(src, s) + len;
			dst[d] = port_bytes(dst, d) + len;
		end else if (s > LAST_WELL_KNOWN && d > LAST_WELL_KNOWN) begin
			src[s] = port_bytes(src, s) + len;
			dst[d] = port_bytes(dst, d) + len;
			high += len;
		end
		total += len;
	endtask

	function automatic read_exp_t read_counter(logic [3:0] tbl, logic [15:0] idx);
		read_exp_t r;
		r.value = 64'd0;
		r.bad = 1'b0;
		case (tbl)
			TBL_TCP_SRC: r.value = port_bytes(tcp_src, idx);
			TBL_TCP_DST: r.value = port_bytes(tcp_dst, idx);
			TBL_UDP_SRC: r.value = port_bytes(udp_src, idx);
			TBL_UDP_DST: r.value = port_bytes(udp_dst, idx);
			TBL_ICMP: begin
				if (idx < ICMP_TYPES) r.value = icmp_bytes[idx];
				else r.bad = 1'b1;
			end
			TBL_HIST: begin
				if (idx < HIST_BINS) r.value = len_hist[idx];
				else r.bad = 1'b1;
			end
			TBL_TCP_HIGH:   r.value = tcp_high;
			TBL_TCP_TOTAL:  r.value = tcp_total;
			TBL_UDP_HIGH:   r.value = udp_high;
			TBL_UDP_TOTAL:  r.value = udp_total;
			TBL_ICMP_TOTAL: r.value = icmp_total;
			TBL_PKT_COUNT:  r.value = pkt_count;
			TBL_BYTE_COUNT: r.value = byte_count;
			default:        r.bad = 1'b1;
		endcase
		return r;
	endfunction

	task automatic take_item();
		bit [63:0] len;
		len = {48'd0, pkt_in.pkt_length};
		if (pkt_in.op == OP_READ) begin
			read_q.push_back(read_counter(pkt_in.read_table, pkt_in.read_index));
		end else if (pkt_in.op < OP_READ) begin
			case (pkt_in.op)
				OP_TCP: count_ports(tcp_src, tcp_dst, tcp_high, tcp_total,
					pkt_in.src_port, pkt_in.dst_port, len);
				OP_UDP: count_ports(udp_src, udp_dst, udp_high, udp_total,
					pkt_in.src_port, pkt_in.dst_port, len);
				OP_ICMP: begin
					icmp_bytes[pkt_in.icmp_type] += len;
					icmp_total += len;
				end
				default: ;
			endcase
			if (pkt_in.pkt_length <= HIST_MAX_LEN) len_hist[pkt_in.pkt_length] += 1;
			else len_hist[HIST_MAX_LEN + 1] += 1;
			pkt_count += 1;
			byte_count += len;
			pkts_seen++;
		end
	endtask

	task automatic check_result();
		read_exp_t e;
		reads_seen++;
		if (read_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result value=%h bad=%b", $time,
				res_out.read_value, res_out.index_bad);
		end else begin
			e = read_q.pop_front();
			if (res_out.read_value !== e.value) begin
				errors++;
				$display("%0t: read_value expected %h actual %h", $time, e.value,
					res_out.read_value);
			end
			if (res_out.index_bad !== e.bad) begin
				errors++;
				$display("%0t: index_bad expected %b actual %b", $time, e.bad,
					res_out.index_bad);
			end
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		reads_seen = 0;
		pkts_seen = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_out.valid && res_out.ready) check_result();
			if (pkt_in.valid && pkt_in.ready) take_item();
			pending = read_q.size();
		end
	end
endmodule

>>> tb/tb_top.sv
// Top of the statistics counter testbench: clock, reset, item stimulus,
// result stall pattern and verdict. Uses tfsc_pkg, tfsc_if and tfsc_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tfsc_pkg::*;

	localparam int RAND_ITEMS = 1100;
	localparam int QUIET_TAIL = 150;
	localparam longint CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	int errors, pending, reads_seen, pkts_seen;
	longint cycles;
	bit quiet;
	logic [15:0] port_pool [16];

	tfsc_in_if pkt_in();
	tfsc_out_if res_out();

	traffic_flow_statistics_counter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt_in (pkt_in.sink),
		.res_out(res_out.source)
	);

	tfsc_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_in    (pkt_in.sink),
		.res_out   (res_out.sink),
		.errors    (errors),
		.pending   (pending),
		.reads_seen(reads_seen),
		.pkts_seen (pkts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// result side stalls in bursts, none during the quiet tail
	initial begin
		int stall;
		stall = 0;
		res_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				res_out.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall = int'($urandom_range(0, 3));
				res_out.ready <= 1'b0;
			end else begin
				res_out.ready <= 1'b1;
			end
		end
	end

	task automatic send(logic [2:0] op, logic [15:0] s, logic [15:0] d, logic [7:0] ty,
			logic [15:0] len, logic [3:0] tbl, logic [15:0] idx);
		bit took;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			pkt_in.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pkt_in.valid      <= 1'b1;
		pkt_in.op         <= op;
		pkt_in.src_port   <= s;
		pkt_in.dst_port   <= d;
		pkt_in.icmp_type  <= ty;
		pkt_in.pkt_length <= len;
		pkt_in.read_table <= tbl;
		pkt_in.read_index <= idx;
		do begin
			@(negedge clk);
			took = pkt_in.ready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 9))
			0:       return 16'd1023;
			1:       return 16'($urandom_range(0, 1022));
			2:       return 16'($urandom);
			default: return port_pool[$urandom_range(0, 15)];
		endcase
	endfunction

	function automatic logic [15:0] pick_len();
		case ($urandom_range(0, 7))
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(4095, 4098));
			2:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 1500));
		endcase
	endfunction

	task automatic send_read(logic [3:0] tbl);
		logic [15:0] idx;
		case (tbl)
			TBL_ICMP: idx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 255));
			TBL_HIST: idx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: (($urandom_range(0, 1) == 1) ? 16'($urandom_range(4090, 4098))
				: 16'($urandom_range(0, 1500)));
			default: idx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pick_port();
		endcase
		send(OP_READ, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
			tbl, idx);
	endtask

	initial begin
		logic [2:0] op;
		pkt_in.valid = 1'b0;
		pkt_in.op = OP_OTHER;
		pkt_in.src_port = '0;
		pkt_in.dst_port = '0;
		pkt_in.icmp_type = '0;
		pkt_in.pkt_length = '0;
		pkt_in.read_table = TBL_TCP_SRC;
		pkt_in.read_index = '0;
		quiet = 1'b0;
		foreach (port_pool[i]) port_pool[i] = 16'($urandom);
		port_pool[0] = 16'd0;
		port_pool[1] = 16'd1022;
		port_pool[2] = 16'd1024;
		port_pool[3] = 16'hFFFF;
		port_pool[4] = 16'd80;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each port rule, 1023 pairs, icmp extremes, length bins
		send(OP_TCP, 16'd80, 16'd5000, 8'd0, 16'd100, TBL_TCP_SRC, 16'd0);
		send(OP_TCP, 16'd5000, 16'd22, 8'd0, 16'd200, TBL_TCP_SRC, 16'd0);
		send(OP_TCP, 16'd0, 16'd1022, 8'd0, 16'd0, TBL_TCP_SRC, 16'd0);
		send(OP_TCP, 16'hFFFF, 16'd1024, 8'd0, 16'd4096, TBL_TCP_SRC, 16'd0);
		send(OP_TCP, 16'd1023, 16'd1023, 8'd0, 16'd4097, TBL_TCP_SRC, 16'd0);
		send(OP_UDP, 16'd1023, 16'd53, 8'd0, 16'hFFFF, TBL_TCP_SRC, 16'd0);
		send(OP_UDP, 16'd53, 16'd1023, 8'd0, 16'd64, TBL_TCP_SRC, 16'd0);
		send(OP_UDP, 16'd2000, 16'hFFFF, 8'd0, 16'd1500, TBL_TCP_SRC, 16'd0);
		send(OP_ICMP, 16'd0, 16'd0, 8'd0, 16'd84, TBL_TCP_SRC, 16'd0);
		send(OP_ICMP, 16'd0, 16'd0, 8'hFF, 16'd4098, TBL_TCP_SRC, 16'd0);
		send(OP_OTHER, 16'hFFFF, 16'hFFFF, 8'hFF, 16'd60, TBL_TCP_SRC, 16'd0);
		send(3'd5, 16'd80, 16'd80, 8'd1, 16'd10, TBL_TCP_SRC, 16'd0);
		send(3'd7, 16'd80, 16'd80, 8'd1, 16'd10, TBL_TCP_SRC, 16'd0);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_TCP_SRC, 16'd80);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_TCP_SRC, 16'hFFFF);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_TCP_DST, 16'd22);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_UDP_DST, 16'd53);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_ICMP, 16'd255);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_ICMP, 16'd256);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_HIST, 16'd4097);
		send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, TBL_HIST, 16'd4098);
		for (int t = TBL_TCP_HIGH; t <= 15; t++)
			send(OP_READ, 16'd0, 16'd0, 8'd0, 16'd0, 4'(t), 16'hFFFF);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				// drain everything before carrying on
				pkt_in.valid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
			case ($urandom_range(0, 19))
				0:              op = 3'($urandom_range(5, 7));
				1, 2, 3, 4, 5, 6, 7: op = OP_READ;
				default:        op = 3'($urandom_range(0, 3));
			endcase
			if (op == OP_READ) send_read(4'($urandom));
			else send(op, pick_port(), pick_port(), 8'($urandom), pick_len(),
				4'($urandom), 16'($urandom));
		end
		pkt_in.valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("covered %0d packets and %0d counter reads, all port rules,", pkts_seen,
			reads_seen);
		$display("histogram overflow bin, bad indexes and unused codes");
		if (errors == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
